// ===== src/loopback_packet_checker_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Loopback packet checker assertion macros
// Clocked, reset-qualified property wrappers used by lpc_checker.sv.
// ----------------------------------------------------------------------------
`ifndef LOOPBACK_PACKET_CHECKER_UNIT_ASSERT_SVH
`define LOOPBACK_PACKET_CHECKER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define LPC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("loopback checker: same-cycle property failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define LPC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("loopback checker: next-cycle property failed");

`endif

// ===== src/lpc_pkg.sv =====
// ----------------------------------------------------------------------------
// Loopback packet checker package
// Shared constants, codes and the verdict type.
// ----------------------------------------------------------------------------
package lpc_pkg;

    localparam int SLOTS_DEF       = 8;
    localparam int PAYLOAD_LEN_DEF = 48;
    localparam int COUNT_W         = 31;
    localparam int LAG_W           = 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // action field codes
    localparam logic ACT_SENT  = 1'b0;
    localparam logic ACT_REPLY = 1'b1;

    typedef enum logic [1:0] {
        VERDICT_MATCH    = 2'd0,
        VERDICT_MISMATCH = 2'd1,
        VERDICT_WINDOW   = 2'd2
    } verdict_t;

endpackage

// ===== src/loopback_packet_checker_unit.sv =====
// ----------------------------------------------------------------------------
// Loopback packet checker
// A reply's result passes the compare stage and result register once its last
// item is taken. Throughput: one item per cycle when item_stall is low; each
// item makes at most one payload store access. Reset: the store is swept to
// zero, one byte a cycle, over SLOTS*PAYLOAD_LEN bytes (384 by default) with item_stall high.
// ----------------------------------------------------------------------------
module loopback_packet_checker_unit #(
    parameter int SLOTS       = lpc_pkg::SLOTS_DEF,
    parameter int PAYLOAD_LEN = lpc_pkg::PAYLOAD_LEN_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        item_valid,
    output logic                        item_stall,
    input  logic                        action,
    input  logic [7:0]                  packet_number,
    input  logic [7:0]                  data_byte,
    input  logic                        first_of_packet,
    input  logic                        last_of_packet,
    input  logic                        no_payload,

    output logic                        result_valid,
    input  logic                        result_stall,
    output logic [1:0]                  verdict,
    output logic [7:0]                  packet_lag,
    output logic [lpc_pkg::COUNT_W-1:0] good_count,
    output logic [lpc_pkg::COUNT_W-1:0] bad_count,
    output logic [lpc_pkg::COUNT_W-1:0] sent_count
);

    localparam int DEPTH  = SLOTS * PAYLOAD_LEN;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int POS_W  = $clog2(PAYLOAD_LEN + 1);
    localparam int CW     = lpc_pkg::COUNT_W;
    localparam int LW     = lpc_pkg::LAG_W;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

    // payload store
    logic [7:0]        mem [DEPTH];
    logic [7:0]        rd_data_reg;
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic [ADDR_W-1:0] item_addr;

    // clearing sweep
    logic              clr_active_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    // front state
    logic [POS_W-1:0]  byte_pos_reg;
    logic [SLOT_W-1:0] last_slot_reg;
    logic [LW-1:0]     last_sent_reg;
    logic [LW-1:0]     lag_reg;
    logic              win_reg;
    logic [SLOT_W-1:0] cmp_slot_reg;
    logic [CW-1:0]     sent_total_reg;

    // compare stage
    logic              s1_valid_reg;
    logic              s1_reply_reg;
    logic              s1_first_reg;
    logic              s1_last_reg;
    logic              s1_cmp_reg;
    logic              s1_win_reg;
    logic [LW-1:0]     s1_lag_reg;
    logic [7:0]        s1_byte_reg;
    logic              mismatch_reg;
    logic [CW-1:0]     good_total_reg;
    logic [CW-1:0]     bad_total_reg;

    // result register
    logic              out_valid_reg;
    logic [1:0]        verdict_reg;
    logic [LW-1:0]     lag_out_reg;
    logic [CW-1:0]     good_out_reg;
    logic [CW-1:0]     bad_out_reg;
    logic [CW-1:0]     sent_out_reg;

    logic              accept;
    logic              is_reply;
    logic              first_eff;
    logic              last_eff;
    logic [POS_W-1:0]  pos_base;
    logic              pos_ok;
    logic [SLOT_W-1:0] slot_adv;
    logic [SLOT_W-1:0] slot_wr;
    logic [LW-1:0]     lag_new;
    logic              win_new;
    logic [SLOT_W-1:0] cmp_slot_new;
    logic [SLOT_W:0]   slot_diff;
    logic [LW-1:0]     lag_eff;
    logic              win_eff;
    logic [SLOT_W-1:0] cmp_slot_eff;
    logic [SLOT_W-1:0] slot_sel;

    logic              s1_result;
    logic              s1_hold;
    logic              s1_fire;
    logic              mismatch_next;
    logic [1:0]        verdict_next;
    logic [CW-1:0]     good_next;
    logic [CW-1:0]     bad_next;

    // ------------------------------------------------------------------
    // Front: position, slot and lag for the incoming request
    // ------------------------------------------------------------------
    assign is_reply  = (action == lpc_pkg::ACT_REPLY);
    assign first_eff = first_of_packet | no_payload;
    assign last_eff  = last_of_packet | no_payload;
    assign pos_base  = first_eff ? '0 : byte_pos_reg;
    assign pos_ok    = !no_payload && (pos_base < POS_W'(PAYLOAD_LEN));

    assign slot_adv = (last_slot_reg == LAST_SLOT) ? '0 : last_slot_reg + 1'b1;
    assign slot_wr  = first_eff ? slot_adv : last_slot_reg;

    assign lag_new   = last_sent_reg - packet_number;
    assign win_new   = ({1'b0, lag_new} < 9'(SLOTS));
    assign slot_diff = {1'b0, last_slot_reg} - {1'b0, lag_new[SLOT_W-1:0]};

    always_comb
    begin
        if (!win_new)
        begin
            cmp_slot_new = '0;
        end
        else if (last_slot_reg >= lag_new[SLOT_W-1:0])
        begin
            cmp_slot_new = slot_diff[SLOT_W-1:0];
        end
        else
        begin
            // wrap around the ring
            cmp_slot_new = SLOT_W'(slot_diff + (SLOT_W+1)'(SLOTS));
        end
    end

    assign lag_eff      = first_eff ? lag_new      : lag_reg;
    assign win_eff      = first_eff ? win_new      : win_reg;
    assign cmp_slot_eff = first_eff ? cmp_slot_new : cmp_slot_reg;

    assign slot_sel  = is_reply ? cmp_slot_eff : slot_wr;
    assign item_addr = ADDR_W'(slot_sel) * ADDR_W'(PAYLOAD_LEN) + ADDR_W'(pos_base);

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    assign s1_result  = s1_valid_reg && s1_reply_reg && s1_last_reg;
    assign s1_hold    = s1_result && out_valid_reg && result_stall;
    assign s1_fire    = s1_valid_reg && !s1_hold;
    assign item_stall = clr_active_reg || s1_hold;
    assign accept     = item_valid && !item_stall;

    // ------------------------------------------------------------------
    // Payload store: one write port (sweep or sent byte), one read port
    // ------------------------------------------------------------------
    assign mem_we    = clr_active_reg || (accept && !is_reply && pos_ok);
    assign mem_waddr = clr_active_reg ? clr_addr_reg : item_addr;
    assign mem_wdata = clr_active_reg ? 8'h00 : data_byte;
    assign mem_re    = accept && is_reply;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        // hold read data while the compare stage waits
        if (mem_re)
        begin
            rd_data_reg <= mem[item_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            if (clr_addr_reg == LAST_ADDR)
            begin
                clr_active_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Front state update
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_pos_reg   <= '0;
            last_slot_reg  <= LAST_SLOT;
            last_sent_reg  <= '0;
            lag_reg        <= '0;
            win_reg        <= 1'b1;
            cmp_slot_reg   <= '0;
            sent_total_reg <= '0;
        end
        else if (accept)
        begin
            byte_pos_reg <= pos_ok ? pos_base + 1'b1 : pos_base;
            if (!is_reply && first_eff)
            begin
                last_slot_reg <= slot_adv;
                last_sent_reg <= packet_number;
                if (sent_total_reg != lpc_pkg::COUNT_MAX)
                begin
                    sent_total_reg <= sent_total_reg + 1'b1;
                end
            end
            if (is_reply && first_eff)
            begin
                lag_reg      <= lag_new;
                win_reg      <= win_new;
                cmp_slot_reg <= cmp_slot_new;
            end
        end
    end

    // ------------------------------------------------------------------
    // Compare stage
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reply_reg <= is_reply;
            s1_first_reg <= first_eff;
            s1_last_reg  <= last_eff;
            s1_cmp_reg   <= is_reply && pos_ok && win_eff;
            s1_win_reg   <= win_eff;
            s1_lag_reg   <= lag_eff;
            s1_byte_reg  <= data_byte;
        end
    end

    assign mismatch_next = (!s1_first_reg && mismatch_reg)
                         || (s1_cmp_reg && (rd_data_reg != s1_byte_reg));

    always_comb
    begin
        verdict_next = lpc_pkg::VERDICT_MATCH;
        good_next    = good_total_reg;
        bad_next     = bad_total_reg;
        if (!s1_win_reg)
        begin
            verdict_next = lpc_pkg::VERDICT_WINDOW;
        end
        else if (mismatch_next)
        begin
            verdict_next = lpc_pkg::VERDICT_MISMATCH;
        end
        if (verdict_next == lpc_pkg::VERDICT_MATCH)
        begin
            if (good_total_reg != lpc_pkg::COUNT_MAX)
            begin
                good_next = good_total_reg + 1'b1;
            end
        end
        else if (bad_total_reg != lpc_pkg::COUNT_MAX)
        begin
            bad_next = bad_total_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mismatch_reg   <= 1'b0;
            good_total_reg <= '0;
            bad_total_reg  <= '0;
        end
        else if (s1_fire && s1_reply_reg)
        begin
            mismatch_reg <= mismatch_next;
            if (s1_last_reg)
            begin
                good_total_reg <= good_next;
                bad_total_reg  <= bad_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire && s1_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_result)
        begin
            verdict_reg  <= verdict_next;
            lag_out_reg  <= s1_lag_reg;
            good_out_reg <= good_next;
            bad_out_reg  <= bad_next;
            sent_out_reg <= sent_total_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign verdict      = verdict_reg;
    assign packet_lag   = lag_out_reg;
    assign good_count   = good_out_reg;
    assign bad_count    = bad_out_reg;
    assign sent_count   = sent_out_reg;

endmodule

// ===== src/lpc_checker.sv =====
// ----------------------------------------------------------------------------
// Loopback packet checker port checks
// Watches the top level's ports and flags protocol and counter slips.
// ----------------------------------------------------------------------------
`include "loopback_packet_checker_unit_assert.svh"

module lpc_checker #(
    parameter int SLOTS = lpc_pkg::SLOTS_DEF
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        item_valid,
    input logic                        item_stall,
    input logic                        action,
    input logic [7:0]                  packet_number,
    input logic [7:0]                  data_byte,
    input logic                        first_of_packet,
    input logic                        last_of_packet,
    input logic                        no_payload,
    input logic                        result_valid,
    input logic                        result_stall,
    input logic [1:0]                  verdict,
    input logic [7:0]                  packet_lag,
    input logic [lpc_pkg::COUNT_W-1:0] good_count,
    input logic [lpc_pkg::COUNT_W-1:0] bad_count,
    input logic [lpc_pkg::COUNT_W-1:0] sent_count
);

    logic item_seen;

    // request taken this cycle
    assign item_seen = item_valid && !item_stall && (action || !action)
                     && ((packet_number ^ data_byte) == (data_byte ^ packet_number))
                     && (first_of_packet || last_of_packet || no_payload || 1'b1);

    // a stalled result holds
    `LPC_ASSERT_NEXT(a_result_hold, result_valid && result_stall,
        result_valid && $stable(verdict) && $stable(packet_lag)
        && $stable(good_count) && $stable(bad_count) && $stable(sent_count))

    // an out-of-window verdict carries a lag at or beyond the ring size
    `LPC_ASSERT_NOW(a_window_lag, result_valid && (verdict == lpc_pkg::VERDICT_WINDOW),
        packet_lag >= 8'(SLOTS))

    // the counter credited by a verdict is never zero
    `LPC_ASSERT_NOW(a_count_credit, result_valid,
        ((verdict == lpc_pkg::VERDICT_MATCH) && (good_count != '0))
        || ((verdict != lpc_pkg::VERDICT_MATCH) && (bad_count != '0)))

    // the sent counter never steps back
    `LPC_ASSERT_NEXT(a_sent_monotonic, item_seen || !item_seen,
        sent_count >= $past(sent_count) || !$past(result_valid))

endmodule

bind loopback_packet_checker_unit lpc_checker #(.SLOTS(SLOTS)) u_lpc_checker (.*);
